// File: hw/rtl/symmetric_tensor_inverse_unit_defines.svh
// Assertion macros shared by the symmetric tensor inverse RTL.
`ifndef SYMMETRIC_TENSOR_INVERSE_UNIT_DEFINES_SVH
`define SYMMETRIC_TENSOR_INVERSE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define STINV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define STINV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/stinv_pkg.sv
// Shared types for the symmetric tensor inverse pipeline.
package stinv_pkg;
	typedef struct packed {
		logic adv; // whole pipeline moves one stage
	} ctl_t;
endpackage

// File: hw/rtl/stinv_tensor_if.sv
// Input channel: one symmetric tensor per item.
interface stinv_tensor_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] t_xx;
	logic signed [DATA_WIDTH-1:0] t_xy;
	logic signed [DATA_WIDTH-1:0] t_xz;
	logic signed [DATA_WIDTH-1:0] t_yy;
	logic signed [DATA_WIDTH-1:0] t_yz;
	logic signed [DATA_WIDTH-1:0] t_zz;
	modport source(output valid, t_xx, t_xy, t_xz, t_yy, t_yz, t_zz, input ready);
	modport sink(input valid, t_xx, t_xy, t_xz, t_yy, t_yz, t_zz, output ready);
endinterface

// File: hw/rtl/stinv_inverse_if.sv
// Output channel: one inverse tensor plus flags per item.
interface stinv_inverse_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] inv_xx;
	logic signed [DATA_WIDTH-1:0] inv_xy;
	logic signed [DATA_WIDTH-1:0] inv_xz;
	logic signed [DATA_WIDTH-1:0] inv_yy;
	logic signed [DATA_WIDTH-1:0] inv_yz;
	logic signed [DATA_WIDTH-1:0] inv_zz;
	logic singular;
	logic saturated;
	modport source(output valid, inv_xx, inv_xy, inv_xz, inv_yy, inv_yz, inv_zz,
		singular, saturated, input ready);
	modport sink(input valid, inv_xx, inv_xy, inv_xz, inv_yy, inv_yz, inv_zz,
		singular, saturated, output ready);
endinterface

// File: hw/rtl/symmetric_tensor_inverse_unit.sv
// Top level of the symmetric 3x3 tensor inverse pipeline.
//
// Usage notes:
// - tensor channel: one symmetric tensor (xx, xy, xz, yy, yz, zz) per item,
//   signed fixed point with FRAC_BITS fraction bits.
// - inverse channel: the six inverse components in the same format, plus
//   singular (zero determinant, all components zero) and saturated (some
//   component clipped to the signed range).
// - Pipeline: DATA_WIDTH + 8 register stages from the accepted item to the
//   result on the inverse channel. Six stages form the cofactors and
//   determinant, then one restoring divider per component resolves one
//   quotient bit per stage after an overflow precheck, and a last stage
//   signs and clips.
// - Throughput: one item per cycle when the receiver keeps ready high.
// - Stall: when the result is held and the receiver is not ready, the whole
//   pipeline freezes; nothing is dropped or repeated, and tensor.ready drops.
// - Reset: arst_n clears every valid bit; the pipeline comes up empty.
//
`include "symmetric_tensor_inverse_unit_defines.svh"
module symmetric_tensor_inverse_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input logic clk,
	input logic arst_n,
	stinv_tensor_if.sink    tensor,
	stinv_inverse_if.source inverse
);
	import stinv_pkg::*;
	localparam int W   = DATA_WIDTH;
	localparam int CW  = 2*W + 1;
	localparam int NW  = CW + 2*FRAC_BITS;
	localparam int DW  = 3*W + 3;
	localparam int LAT = W + 8;          // total register stages
	localparam int ZD  = W + 2;          // determinant flag to output delay
	localparam logic [W-1:0] HALF = W'(1) << (W-1);

	ctl_t ctl;
	logic [LAT-1:0] valid_q;
	logic [ZD-1:0]  zero_q;

	logic [NW-1:0] num_mag [6];
	logic          num_neg [6];
	logic [DW-1:0] det_mag;
	logic          det_neg;
	logic          det_zero;
	logic signed [W-1:0] quo [6];
	logic [5:0]    sat_k;
	logic          sing;
	logic          clip_seen;

	// global advance: move unless the held result is not being taken
	assign ctl.adv = !valid_q[LAT-1] || inverse.ready;
	assign tensor.ready = ctl.adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.adv) begin
			valid_q <= {valid_q[LAT-2:0], tensor.valid};
		end
	end

	// singular flag rides alongside the dividers
	always_ff @(posedge clk) begin
		if (ctl.adv)
			zero_q <= {zero_q[ZD-2:0], det_zero};
	end

	stinv_adj #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .CW(CW), .NW(NW), .DW(DW)) u_adj (
		.clk(clk), .ctl(ctl),
		.t_xx(tensor.t_xx), .t_xy(tensor.t_xy), .t_xz(tensor.t_xz),
		.t_yy(tensor.t_yy), .t_yz(tensor.t_yz), .t_zz(tensor.t_zz),
		.num_mag(num_mag), .num_neg(num_neg),
		.det_mag(det_mag), .det_neg(det_neg), .det_zero(det_zero)
	);

	for (genvar k = 0; k < 6; k++) begin : g_div
		stinv_div #(.DATA_WIDTH(W), .NW(NW), .DW(DW)) u_div (
			.clk(clk), .ctl(ctl),
			.num_mag(num_mag[k]), .num_neg(num_neg[k]),
			.det_mag(det_mag), .det_neg(det_neg),
			.quo(quo[k]), .sat(sat_k[k])
		);
	end

	// a singular tensor forces zero components and no clip flag
	assign sing              = zero_q[ZD-1];
	assign inverse.valid     = valid_q[LAT-1];
	assign inverse.singular  = sing;
	assign inverse.saturated = !sing && (sat_k != '0);
	assign inverse.inv_xx    = sing ? '0 : quo[0];
	assign inverse.inv_xy    = sing ? '0 : quo[1];
	assign inverse.inv_xz    = sing ? '0 : quo[2];
	assign inverse.inv_yy    = sing ? '0 : quo[3];
	assign inverse.inv_yz    = sing ? '0 : quo[4];
	assign inverse.inv_zz    = sing ? '0 : quo[5];

	always_comb begin
		clip_seen = 1'b0;
		for (int k = 0; k < 6; k++)
			if (quo[k] == HALF || quo[k] == ~HALF)
				clip_seen = 1'b1;
	end

	`STINV_ASSERT_NOW(a_sing_zero, inverse.valid && sing, !inverse.saturated && inverse.inv_xx == '0 && inverse.inv_yy == '0 && inverse.inv_zz == '0, "singular result not zeroed")
	`STINV_ASSERT_NOW(a_sat_bound, inverse.valid && inverse.saturated, clip_seen, "saturated flag without a clipped component")
	`STINV_ASSERT_NEXT(a_enter, tensor.valid && tensor.ready, valid_q[0], "accepted item lost at entry")
endmodule

// File: hw/rtl/stinv_adj.sv
// Cofactors, determinant and operand magnitudes: six register stages.
module stinv_adj #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int CW = 2*DATA_WIDTH + 1,
	parameter int NW = CW + 2*FRAC_BITS,
	parameter int DW = 3*DATA_WIDTH + 3
) (
	input  logic clk,
	input  stinv_pkg::ctl_t ctl,
	input  logic signed [DATA_WIDTH-1:0] t_xx,
	input  logic signed [DATA_WIDTH-1:0] t_xy,
	input  logic signed [DATA_WIDTH-1:0] t_xz,
	input  logic signed [DATA_WIDTH-1:0] t_yy,
	input  logic signed [DATA_WIDTH-1:0] t_yz,
	input  logic signed [DATA_WIDTH-1:0] t_zz,
	output logic [NW-1:0] num_mag [6],
	output logic          num_neg [6],
	output logic [DW-1:0] det_mag,
	output logic          det_neg,
	output logic          det_zero
);
	import stinv_pkg::*;
	localparam int W = DATA_WIDTH;

	logic signed [W-1:0]    xx_s1, xy_s1, xz_s1, yy_s1, yz_s1, zz_s1;
	logic signed [2*W-1:0]  pa_s2 [6];
	logic signed [2*W-1:0]  pb_s2 [6];
	logic signed [W-1:0]    x_s2 [3];
	logic signed [CW-1:0]   cof_s3 [6];
	logic signed [W-1:0]    x_s3 [3];
	logic signed [2*W:0]    ph_s4 [3];
	logic signed [2*W:0]    pl_s4 [3];
	logic signed [CW-1:0]   cof_s4 [6];
	logic signed [DW-1:0]   det_s5;
	logic signed [CW-1:0]   cof_s5 [6];
	logic signed [DW-1:0]   det_sum;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			xx_s1 <= t_xx; xy_s1 <= t_xy; xz_s1 <= t_xz;
			yy_s1 <= t_yy; yz_s1 <= t_yz; zz_s1 <= t_zz;
		end
	end

	// stage 2: the twelve minor products
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			pa_s2[0] <= yy_s1 * zz_s1; pb_s2[0] <= yz_s1 * yz_s1;
			pa_s2[1] <= yz_s1 * xz_s1; pb_s2[1] <= zz_s1 * xy_s1;
			pa_s2[2] <= yz_s1 * xy_s1; pb_s2[2] <= yy_s1 * xz_s1;
			pa_s2[3] <= xx_s1 * zz_s1; pb_s2[3] <= xz_s1 * xz_s1;
			pa_s2[4] <= xy_s1 * xz_s1; pb_s2[4] <= yz_s1 * xx_s1;
			pa_s2[5] <= xx_s1 * yy_s1; pb_s2[5] <= xy_s1 * xy_s1;
			x_s2[0] <= xx_s1; x_s2[1] <= xy_s1; x_s2[2] <= xz_s1;
		end
	end

	// stage 3: cofactors
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int k = 0; k < 6; k++)
				cof_s3[k] <= CW'(pa_s2[k]) - CW'(pb_s2[k]);
			x_s3 <= x_s2;
		end
	end

	// stage 4: first-row products, cofactor split into high and low halves
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int k = 0; k < 3; k++) begin
				ph_s4[k] <= x_s3[k] * $signed(cof_s3[k][CW-1:W]);
				pl_s4[k] <= x_s3[k] * $signed({1'b0, cof_s3[k][W-1:0]});
			end
			cof_s4 <= cof_s3;
		end
	end

	always_comb begin
		det_sum = '0;
		for (int k = 0; k < 3; k++)
			det_sum = det_sum + (DW'(ph_s4[k]) <<< W) + DW'(pl_s4[k]);
	end

	// stage 5: determinant
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			det_s5 <= det_sum;
			cof_s5 <= cof_s4;
		end
	end

	// stage 6: magnitudes and signs for the dividers
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int k = 0; k < 6; k++) begin
				num_neg[k] <= cof_s5[k][CW-1];
				num_mag[k] <= {(cof_s5[k][CW-1] ? CW'(-cof_s5[k]) : CW'(cof_s5[k])),
					{(2*FRAC_BITS){1'b0}}};
			end
			det_neg  <= det_s5[DW-1];
			det_mag  <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			det_zero <= (det_s5 == '0);
		end
	end
endmodule

// File: hw/rtl/stinv_div.sv
// Pipelined restoring divider with saturation: one quotient bit per stage.
module stinv_div #(
	parameter int DATA_WIDTH = 32,
	parameter int NW = 97,
	parameter int DW = 99
) (
	input  logic clk,
	input  stinv_pkg::ctl_t ctl,
	input  logic [NW-1:0] num_mag,
	input  logic          num_neg,
	input  logic [DW-1:0] det_mag,
	input  logic          det_neg,
	output logic signed [DATA_WIDTH-1:0] quo,
	output logic          sat
);
	import stinv_pkg::*;
	localparam int W  = DATA_WIDTH;
	localparam int RW = (DW + W > NW) ? DW + W : NW;
	localparam logic [W-1:0] HALF = W'(1) << (W-1);

	logic [RW-1:0] rem_s [W+1];
	logic [DW-1:0] d_s   [W+1];
	logic [W-1:0]  q_s   [W+1];
	logic          neg_s [W+1];
	logic          ovf_s [W+1];

	// entry stage: a quotient of 2^W or more always clips
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rem_s[0] <= RW'(num_mag);
			d_s[0]   <= det_mag;
			q_s[0]   <= '0;
			neg_s[0] <= num_neg ^ det_neg;
			ovf_s[0] <= RW'(num_mag) >= (RW'(det_mag) << W);
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [RW-1:0] sh;
		logic          ge;
		assign sh = RW'(d_s[k]) << (W-1-k);
		assign ge = rem_s[k] >= sh;
		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rem_s[k+1] <= ge ? rem_s[k] - sh : rem_s[k];
				d_s[k+1]   <= d_s[k];
				q_s[k+1]   <= {q_s[k][W-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// sign and clip
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			if (neg_s[W]) begin
				sat <= ovf_s[W] || (q_s[W] > HALF);
				quo <= (ovf_s[W] || (q_s[W] > HALF)) ? HALF : W'(-q_s[W]);
			end else begin
				sat <= ovf_s[W] || q_s[W][W-1];
				quo <= (ovf_s[W] || q_s[W][W-1]) ? ~HALF : q_s[W];
			end
		end
	end
endmodule

// File: tb/symmetric_tensor_inverse_unit_test.sv
// Testbench for the symmetric 3x3 tensor inverse unit: directed table, random tensors, scoreboard.
`timescale 1ns / 100ps

module symmetric_tensor_inverse_unit_test;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int LATENCY = DW + 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES = 300;
	localparam logic signed [DW-1:0] ONE = 1 <<< FB;
	localparam logic signed [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINN = {1'b1, {(DW-1){1'b0}}};

	// components in order xx, xy, xz, yy, yz, zz
	typedef struct packed {
		logic signed [5:0][DW-1:0] comp;
	} tensor_t;

	typedef struct packed {
		logic signed [5:0][DW-1:0] comp;
		logic singular;
		logic saturated;
	} inverse_t;

	typedef struct {
		tensor_t  tensor;
		bit       known;    // expected result typed in by hand
		inverse_t result;
	} vector_t;

	logic clk;
	logic arst_n;

	stinv_tensor_if  #(.DATA_WIDTH(DW)) tensor_ch ();
	stinv_inverse_if #(.DATA_WIDTH(DW)) inverse_ch ();

	symmetric_tensor_inverse_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tensor  (tensor_ch),
		.inverse (inverse_ch)
	);

	inverse_t  pending_inverses[$];
	vector_t   vectors[$];
	int        errors = 0;
	int        results_seen = 0;
	int        cycles = 0;
	int        hold_left = 0;
	bit        hold_done = 0;
	bit        steady_rx = 0;   // stretch with ready held high
	bit        steady_tx = 0;   // stretch with no gaps on the sender side

	// Clock: 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Adjugate inverse: exact cofactors and determinant at 256 bits, then a
	// truncating divide of cofactor * 2^(2*FB) by the determinant.
	function automatic inverse_t invert_tensor(tensor_t t);
		logic signed [255:0] xx, xy, xz, yy, yz, zz, det, num, q;
		logic signed [255:0] cof[6];
		logic signed [255:0] hi, lo;
		inverse_t r;
		// element selects of a packed array are unsigned
		xx = $signed(t.comp[0]);
		xy = $signed(t.comp[1]);
		xz = $signed(t.comp[2]);
		yy = $signed(t.comp[3]);
		yz = $signed(t.comp[4]);
		zz = $signed(t.comp[5]);
		hi = MAXP;
		lo = MINN;
		cof[0] = yy * zz - yz * yz;
		cof[1] = yz * xz - zz * xy;
		cof[2] = yz * xy - yy * xz;
		cof[3] = xx * zz - xz * xz;
		cof[4] = xy * xz - yz * xx;
		cof[5] = xx * yy - xy * xy;
		det = xx * cof[0] + xy * cof[1] + xz * cof[2];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int k = 0; k < 6; k++) begin
			num = cof[k] <<< (2 * FB);
			q = num / det;
			if (q > hi) begin
				q = hi;
				r.saturated = 1'b1;
			end else if (q < lo) begin
				q = lo;
				r.saturated = 1'b1;
			end
			r.comp[k] = q[DW-1:0];
		end
		return r;
	endfunction

	function automatic tensor_t make_tensor(logic signed [DW-1:0] a, b, c, d, e, f);
		tensor_t t;
		t.comp[0] = a; t.comp[1] = b; t.comp[2] = c;
		t.comp[3] = d; t.comp[4] = e; t.comp[5] = f;
		return t;
	endfunction

	function automatic inverse_t make_inverse(logic signed [DW-1:0] a, b, c, d, e, f,
			logic sing, logic sat);
		inverse_t r;
		tensor_t t;
		t = make_tensor(a, b, c, d, e, f);
		r.comp = t.comp;
		r.singular = sing;
		r.saturated = sat;
		return r;
	endfunction

	function automatic void add_row(tensor_t t, bit known, inverse_t r);
		vector_t v;
		v.tensor = t;
		v.known = known;
		v.result = r;
		vectors.push_back(v);
	endfunction

	// Directed table. Rows with known = 0 are checked against the predictor.
	function automatic void build_table();
		inverse_t none;
		none = '0;
		// identity in, identity out
		add_row(make_tensor(ONE, 0, 0, ONE, 0, ONE), 1,
			make_inverse(ONE, 0, 0, ONE, 0, ONE, 0, 0));
		// 2.0 * I gives 0.5 * I
		add_row(make_tensor(2 * ONE, 0, 0, 2 * ONE, 0, 2 * ONE), 1,
			make_inverse(ONE / 2, 0, 0, ONE / 2, 0, ONE / 2, 0, 0));
		// zero tensor: singular, all outputs zero
		add_row(make_tensor(0, 0, 0, 0, 0, 0), 1, make_inverse(0, 0, 0, 0, 0, 0, 1, 0));
		// all components equal: rank one, singular
		add_row(make_tensor(ONE, ONE, ONE, ONE, ONE, ONE), 1,
			make_inverse(0, 0, 0, 0, 0, 0, 1, 0));
		// tiny positive diagonal: inverse far too large, clips high
		add_row(make_tensor(1, 0, 0, 1, 0, 1), 1,
			make_inverse(MAXP, 0, 0, MAXP, 0, MAXP, 0, 1));
		// tiny negative diagonal: clips low
		add_row(make_tensor(-1, 0, 0, -1, 0, -1), 1,
			make_inverse(MINN, 0, 0, MINN, 0, MINN, 0, 1));
		// -I gives -I
		add_row(make_tensor(-ONE, 0, 0, -ONE, 0, -ONE), 1,
			make_inverse(-ONE, 0, 0, -ONE, 0, -ONE, 0, 0));
		// extremes of the fields
		add_row(make_tensor(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP), 0, none);
		add_row(make_tensor(MINN, MINN, MINN, MINN, MINN, MINN), 0, none);
		add_row(make_tensor(MAXP, 0, 0, MAXP, 0, MAXP), 0, none);
		add_row(make_tensor(MINN, 0, 0, MINN, 0, MINN), 0, none);
		add_row(make_tensor(MAXP, MINN, MAXP, MINN, MAXP, MINN), 0, none);
		add_row(make_tensor(MINN, MAXP, MINN, MAXP, MINN, MAXP), 0, none);
		add_row(make_tensor(-1, -1, -1, -1, -1, -1), 0, none);
		add_row(make_tensor(MAXP, 1, -1, MAXP, MINN, MAXP), 0, none);
		// truncation toward zero, both signs
		add_row(make_tensor(3 * ONE, 0, 0, 3 * ONE, 0, -3 * ONE), 0, none);
		add_row(make_tensor(3 * ONE, ONE, -ONE, 2 * ONE, ONE / 2, 5 * ONE), 0, none);
		add_row(make_tensor(-7, 3, 2, 5, -1, 9), 0, none);
		// off-diagonal only
		add_row(make_tensor(0, ONE, ONE, 0, ONE, 0), 0, none);
		add_row(make_tensor(0, -ONE, 0, 0, 0, ONE), 0, none);
	endfunction

	function automatic logic signed [DW-1:0] rand_comp(int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 2 * ONE) - ONE;
			2: return $urandom_range(0, 20) - 10;
			default: return ($urandom_range(0, 64) - 32) <<< FB;
		endcase
	endfunction

	function automatic tensor_t random_tensor();
		tensor_t t;
		int kind;
		int pick;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 3);
		for (int k = 0; k < 6; k++)
			t.comp[k] = rand_comp(kind);
		if (pick < 30) begin
			// diagonal raised by 4.0 toward a well conditioned tensor
			t.comp[0] = t.comp[0] + 4 * ONE;
			t.comp[3] = t.comp[3] + 4 * ONE;
			t.comp[5] = t.comp[5] + 4 * ONE;
		end else if (pick < 40) begin
			// second row equal to first: singular
			t.comp[3] = t.comp[0];
			t.comp[1] = t.comp[0];
			t.comp[4] = t.comp[2];
		end
		return t;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item and hold it until accepted; the prediction is queued at
	// the accepting edge. valid stays high into the next item when no gap follows.
	task automatic offer_tensor(tensor_t t, inverse_t expected);
		int gap;
		tensor_ch.valid <= 1'b1;
		tensor_ch.t_xx <= t.comp[0];
		tensor_ch.t_xy <= t.comp[1];
		tensor_ch.t_xz <= t.comp[2];
		tensor_ch.t_yy <= t.comp[3];
		tensor_ch.t_yz <= t.comp[4];
		tensor_ch.t_zz <= t.comp[5];
		do
			@(posedge clk);
		while (!tensor_ch.ready);
		pending_inverses.push_back(expected);
		gap = steady_tx ? 0 : gap_length();
		if (gap > 0) begin
			tensor_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender
	initial begin
		tensor_t t;
		tensor_ch.valid = 1'b0;
		tensor_ch.t_xx = '0;
		tensor_ch.t_xy = '0;
		tensor_ch.t_xz = '0;
		tensor_ch.t_yy = '0;
		tensor_ch.t_yz = '0;
		tensor_ch.t_zz = '0;
		arst_n = 1'b0;
		build_table();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (vectors[i])
			offer_tensor(vectors[i].tensor,
				vectors[i].known ? vectors[i].result : invert_tensor(vectors[i].tensor));
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				steady_tx = ($urandom_range(0, 2) == 0);
			t = random_tensor();
			offer_tensor(t, invert_tensor(t));
		end
		tensor_ch.valid <= 1'b0;
		while (pending_inverses.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial inverse_ch.ready = 1'b0;

	// Receiver: checks each accepted result against the oldest prediction,
	// then picks ready for the next cycle. One long hold-off fills the pipe.
	always @(posedge clk) begin
		inverse_t got, want;
		if (arst_n) begin
			if (inverse_ch.valid && inverse_ch.ready) begin
				got.comp[0] = inverse_ch.inv_xx;
				got.comp[1] = inverse_ch.inv_xy;
				got.comp[2] = inverse_ch.inv_xz;
				got.comp[3] = inverse_ch.inv_yy;
				got.comp[4] = inverse_ch.inv_yz;
				got.comp[5] = inverse_ch.inv_zz;
				got.singular = inverse_ch.singular;
				got.saturated = inverse_ch.saturated;
				results_seen++;
				if (pending_inverses.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, got);
				end else begin
					want = pending_inverses.pop_front();
					for (int k = 0; k < 6; k++)
						if (got.comp[k] !== want.comp[k]) begin
							errors++;
							$display("%0t: component %0d expected %0d got %0d",
								$time, k, want.comp[k], got.comp[k]);
						end
					if (got.singular !== want.singular) begin
						errors++;
						$display("%0t: singular expected %b got %b",
							$time, want.singular, got.singular);
					end
					if (got.saturated !== want.saturated) begin
						errors++;
						$display("%0t: saturated expected %b got %b",
							$time, want.saturated, got.saturated);
					end
				end
			end
			if (!hold_done && results_seen >= 150) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (results_seen % 60 == 0)
				steady_rx = ($urandom_range(0, 2) == 0);
			if (hold_left > 0) begin
				hold_left--;
				inverse_ch.ready <= 1'b0;
			end else if (steady_rx) begin
				inverse_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 4) begin
				hold_left = $urandom_range(10, 40);
				inverse_ch.ready <= 1'b0;
			end else begin
				inverse_ch.ready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/stinv_pkg.sv
hw/rtl/stinv_tensor_if.sv
hw/rtl/stinv_inverse_if.sv
hw/rtl/stinv_adj.sv
hw/rtl/stinv_div.sv
hw/rtl/symmetric_tensor_inverse_unit.sv
tb/symmetric_tensor_inverse_unit_test.sv
